// File: src/kpsd_pkg.sv
package kpsd_pkg;

   localparam int NUM_KEYS  = 12;
   localparam int KEY_W     = 4;

   typedef logic [NUM_KEYS-1:0] scan_type;
   typedef logic [KEY_W-1:0]    key_num_type;

   // keypad code for raw key 1..12; entry 0 is the no-press code
   localparam key_num_type KEY_CODE_TABLE [0:NUM_KEYS] = '{
      4'd0, 4'd3, 4'd6, 4'd9, 4'd11, 4'd2, 4'd5, 4'd8, 4'd0, 4'd1, 4'd4, 4'd7, 4'd12
   };

endpackage

// File: src/keypad_scan_debounce.sv
// Channel   Ports                                         Direction
// req       req_valid, req_ready, req_scan_word           in  (one scan sample per item)
// rsp       rsp_valid, rsp_ready, rsp_key_valid,          out (one result per sample)
//           rsp_key_index, rsp_key_code
//
// One item per cycle sustained while rsp_ready is high; rsp_valid rises as stage 2 advances.
// Stage 1 registers the scan word; stage 2 shifts the histories up to the lowest-numbered
// key that matches, holds those above it and loads the result register in the same cycle.
// Reset clears the key histories and both valid flags.
// A stalled rsp holds its result; stage 1 then fills and req_ready drops.
module keypad_scan_debounce #(
   parameter int STABLE_SAMPLES = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  kpsd_pkg::scan_type     req_scan_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_key_valid,
   output kpsd_pkg::key_num_type  rsp_key_index,
   output kpsd_pkg::key_num_type  rsp_key_code
);
   import kpsd_pkg::*;

   localparam int HIST_W = STABLE_SAMPLES + 1;
   localparam logic [HIST_W-1:0] HIST_MATCH = {1'b1, {STABLE_SAMPLES{1'b0}}};

   typedef logic [HIST_W-1:0] hist_type;

   logic        in_valid_ff;
   scan_type    in_scan_ff;
   hist_type    hist_ff [NUM_KEYS];
   hist_type    hist_in [NUM_KEYS];
   logic        rsp_valid_ff;
   logic        rsp_key_valid_ff, rsp_key_valid_in;
   key_num_type rsp_key_index_ff, rsp_key_index_in;
   key_num_type rsp_key_code_ff,  rsp_key_code_in;
   logic        advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // shift each key up to the first match, stop updating above it
   always_comb begin
      hist_type shifted;
      logic     hit;
      hit              = 1'b0;
      rsp_key_valid_in = 1'b0;
      rsp_key_index_in = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         shifted = {hist_ff[k][HIST_W-2:0], in_scan_ff[k]};
         if (hit) begin
            hist_in[k] = hist_ff[k];
         end else begin
            hist_in[k] = shifted;
            if (shifted == HIST_MATCH) begin
               hit              = 1'b1;
               rsp_key_valid_in = 1'b1;
               rsp_key_index_in = key_num_type'(k + 1);
            end
         end
      end
      rsp_key_code_in = KEY_CODE_TABLE[rsp_key_index_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
            in_scan_ff  <= req_scan_word;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff     <= 1'b1;
            rsp_key_valid_ff <= rsp_key_valid_in;
            rsp_key_index_ff <= rsp_key_index_in;
            rsp_key_code_ff  <= rsp_key_code_in;
            for (int k = 0; k < NUM_KEYS; k++) begin
               hist_ff[k] <= hist_in[k];
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_valid = rsp_key_valid_ff;
   assign rsp_key_index = rsp_key_index_ff;
   assign rsp_key_code  = rsp_key_code_ff;

   a_hit_has_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_key_valid_ff |-> rsp_key_index_ff != '0)
      else $error("press reported without a key index");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_key_valid_ff |-> rsp_key_index_ff == '0 && rsp_key_code_ff == '0)
      else $error("no-press result carries a key");

   a_stall_holds_hist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(hist_ff[0]) && $stable(hist_ff[NUM_KEYS-1]))
      else $error("histories moved while the result stalled");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("buffered sample not processed");

endmodule
